FILE: sv/ksc_pkg.sv
// Package for the keyword substitution cipher.
// Holds action codes, alphabet constants and the controller/datapath link types.
// No dependencies.
package ksc_pkg;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_ENCODE = 2'd2;

    localparam logic [4:0] ALPHA_SIZE = 5'd26;
    localparam logic [4:0] LAST_IDX   = 5'd25;
    localparam logic [7:0] CHAR_A     = 8'd65;
    localparam logic [7:0] CHAR_Z     = 8'd90;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    typedef struct packed {
        logic key_clear;
        logic key_append;
        logic build_start;
        logic build_step;
        logic char_latch;
        logic out_load;
        logic out_from_latch;
    } t_cmd;

    typedef struct packed {
        logic stale;
        logic build_last;
    } t_status;

endpackage

FILE: sv/ksc_dp.sv
// Datapath: keyword store, cipher table, table rebuild counters, output register.
// Depends on ksc_pkg; driven by ksc_ctrl through t_cmd.
module ksc_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [4:0]      i_cfg_wdata,
    input  logic [7:0]      i_char_in,
    input  ksc_pkg::t_cmd   i_cmd,
    output ksc_pkg::t_status o_status,
    output logic [7:0]      o_char_out
);

    logic [4:0]  r_shift;
    logic [25:0] r_in_key;
    logic [4:0]  r_key_pos [26];
    logic [4:0]  r_key_len;
    logic [4:0]  r_table [26];
    logic        r_stale;
    logic [4:0]  r_letter;
    logic [4:0]  r_extra;
    logic [7:0]  r_char;
    logic [7:0]  r_char_out;

    logic [4:0]  n_shift;
    logic [4:0]  app_idx;
    logic        app_upper;
    logic        app_ok;
    logic        is_member;
    logic [6:0]  pos_sum;
    logic [4:0]  pos;
    logic [7:0]  enc_char;
    logic        enc_upper;
    logic [7:0]  enc_off;
    logic [4:0]  enc_entry;

    // shift kept reduced mod 26
    always_comb begin
        if (i_cfg_wdata >= ksc_pkg::ALPHA_SIZE) begin
            n_shift = i_cfg_wdata - ksc_pkg::ALPHA_SIZE;
        end else begin
            n_shift = i_cfg_wdata;
        end
    end

    assign app_upper = (i_char_in >= ksc_pkg::CHAR_A) && (i_char_in <= ksc_pkg::CHAR_Z);
    assign app_idx   = 5'(i_char_in - ksc_pkg::CHAR_A);
    assign app_ok    = app_upper && !r_in_key[app_idx] && (r_key_len < ksc_pkg::ALPHA_SIZE);

    assign is_member = r_in_key[r_letter];

    always_comb begin
        if (is_member) begin
            pos_sum = 7'(r_shift) + 7'(r_key_pos[r_letter]);
        end else begin
            pos_sum = 7'(r_shift) + 7'(r_key_len) + 7'(r_extra);
        end
        if (pos_sum >= 7'(ksc_pkg::ALPHA_SIZE)) begin
            pos = 5'(pos_sum - 7'(ksc_pkg::ALPHA_SIZE));
        end else begin
            pos = 5'(pos_sum);
        end
    end

    assign enc_char  = i_cmd.out_from_latch ? r_char : i_char_in;
    assign enc_upper = (enc_char >= ksc_pkg::CHAR_A) && (enc_char <= ksc_pkg::CHAR_Z);
    assign enc_off   = enc_char - ksc_pkg::CHAR_A;
    assign enc_entry = r_table[enc_off[4:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= '0;
            r_in_key  <= '0;
            r_key_len <= '0;
            r_stale   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_shift <= n_shift;
                r_stale <= 1'b1;
            end
            if (i_cmd.key_clear) begin
                r_in_key  <= '0;
                r_key_len <= '0;
                r_stale   <= 1'b1;
            end
            if (i_cmd.key_append && app_ok) begin
                r_in_key[app_idx] <= 1'b1;
                r_key_len         <= r_key_len + 5'd1;
                r_stale           <= 1'b1;
            end
            if (i_cmd.build_step && (r_letter == ksc_pkg::LAST_IDX)) begin
                r_stale <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_append && app_ok) begin
            r_key_pos[app_idx] <= r_key_len;
        end
        if (i_cmd.build_start) begin
            r_letter <= '0;
            r_extra  <= '0;
        end
        if (i_cmd.build_step) begin
            r_table[pos] <= r_letter;
            r_letter     <= r_letter + 5'd1;
            if (!is_member) begin
                r_extra <= r_extra + 5'd1;
            end
        end
        if (i_cmd.char_latch) begin
            r_char <= i_char_in;
        end
        if (i_cmd.out_load) begin
            r_char_out <= enc_upper ? (ksc_pkg::CHAR_A + 8'(enc_entry)) : ksc_pkg::CHAR_SPACE;
        end
    end

    assign o_status.stale      = r_stale;
    assign o_status.build_last = (r_letter == ksc_pkg::LAST_IDX);
    assign o_char_out          = r_char_out;

endmodule

FILE: sv/ksc_ctrl.sv
// Controller: handshakes and sequencing of table rebuilds and result output.
// Depends on ksc_pkg; commands ksc_dp through t_cmd.
module ksc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_action,
    input  logic             i_out_stall,
    input  ksc_pkg::t_status i_status,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output ksc_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUILD,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_busy;
    logic   in_acc;

    assign out_busy   = r_out_valid && i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || out_busy;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_action)
                        ksc_pkg::ACT_CLEAR:  o_cmd.key_clear  = 1'b1;
                        ksc_pkg::ACT_APPEND: o_cmd.key_append = 1'b1;
                        ksc_pkg::ACT_ENCODE: begin
                            if (i_status.stale) begin
                                o_cmd.build_start = 1'b1;
                                o_cmd.char_latch  = 1'b1;
                                n_state           = S_BUILD;
                            end else begin
                                o_cmd.out_load = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_BUILD: begin
                o_cmd.build_step = 1'b1;
                if (i_status.build_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!out_busy) begin
                    o_cmd.out_load       = 1'b1;
                    o_cmd.out_from_latch = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.out_load || out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/keyword_substitution_cipher.sv
// Keyword substitution cipher, top level: ksc_ctrl and ksc_dp.
// Clear/append act on acceptance. Encode with a current table: result the cycle
// after acceptance, one item per cycle while output is not stalled. Encode
// after key or shift change: table rebuild (one letter per cycle), then S_EMIT.
// Synchronous active-low reset: empty keyword, shift 0, table marked stale.
module keyword_substitution_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_char_out
);

    ksc_pkg::t_cmd    cmd;
    ksc_pkg::t_status status;

    ksc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_out_stall(i_out_stall),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_cmd      (cmd)
    );

    ksc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_char_in  (i_char_in),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_char_out (o_char_out)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.out_load && o_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    a_build_clears_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.build_step && status.build_last && !i_cfg_we |=> !status.stale)
        else $error("table still stale after rebuild");

    a_stale_encode_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_action == ksc_pkg::ACT_ENCODE) && status.stale
        |=> o_in_stall)
        else $error("input not stalled during rebuild");

endmodule
